// File: hdl/cbdf_pkg.sv
`default_nettype none

package cbdf_pkg;

  localparam int unsigned MAX_HALF_WIDTH = 8;
  localparam int unsigned WIN_DEPTH      = 2 * MAX_HALF_WIDTH + 1;

  localparam int unsigned HW_W   = 4;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned RESP_W = 12;
  localparam int unsigned SUM_W  = PIX_W + $clog2(MAX_HALF_WIDTH + 1);
  localparam int unsigned POS_W  = $clog2(WIN_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_HALF_WIDTH + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_HALF_WIDTH);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [HW_W-1:0] HW_RESET = HW_W'(2);
  localparam logic [HW_W-1:0] HW_MIN   = HW_W'(1);
  localparam logic [HW_W-1:0] HW_MAX   = HW_W'(MAX_HALF_WIDTH);

  typedef enum logic {
    OP_RAW    = 1'b0,
    OP_FILTER = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SUM_W-1:0] right_sum;
    logic [SUM_W-1:0] left_sum;
    logic [PIX_W-1:0] raw;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qword_t;

endpackage

`default_nettype wire

// File: hdl/cbdf_front.sv
`default_nettype none

module cbdf_front import cbdf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [HW_W-1:0] half_width_i,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic            path_end_i,
  output qword_t               push_o,
  input  wire logic            q_full_i
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PIX_W-1:0] win_q [WIN_DEPTH];
  logic [PIX_W-1:0] win_d [WIN_DEPTH];

  logic             accept;
  logic [POS_W-1:0] n_pos;
  logic             has_main;
  logic             do_filter;
  logic [SUM_W-1:0] right_sum;
  logic [SUM_W-1:0] left_sum;
  logic [IDX_W-1:0] flush_idx;

  assign in_stall_o = (state_q != ST_RUN) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign n_pos      = POS_W'(half_width_i);
  assign has_main   = pos_q >= n_pos;
  assign do_filter  = pos_q >= (n_pos << 1);
  assign flush_idx  = IDX_W'(cnt_q - CNT_W'(1));

  // The window as it stands once the new sample has been shifted in.
  always_comb begin
    win_d[0] = pixel_i;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  // Right window is the newest N samples, left window the N behind the centre.
  always_comb begin
    logic [POS_W-1:0] left_idx;
    right_sum = '0;
    left_sum  = '0;
    left_idx  = '0;
    for (int k = 0; k < MAX_HALF_WIDTH; k++) begin
      left_idx = n_pos + POS_W'(k) + POS_W'(1);
      if (POS_W'(k) < n_pos) begin
        right_sum = right_sum + SUM_W'(win_d[k]);
        left_sum  = left_sum + SUM_W'(win_d[left_idx]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    push_o  = '0;
    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          push_o.valid           = has_main;
          push_o.entry.op        = do_filter ? OP_FILTER : OP_RAW;
          push_o.entry.right_sum = right_sum;
          push_o.entry.left_sum  = left_sum;
          push_o.entry.raw       = win_d[n_pos];
          push_o.entry.last      = 1'b0;
          if (path_end_i) begin
            state_d = ST_FLUSH;
            pos_d   = '0;
            cnt_d   = has_main ? CNT_W'(half_width_i) : CNT_W'(pos_q) + CNT_W'(1);
          end else if (pos_q < POS_W'(WIN_DEPTH)) begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!q_full_i) begin
          push_o.valid     = 1'b1;
          push_o.entry.op  = OP_RAW;
          push_o.entry.raw = win_q[flush_idx];
          push_o.entry.last = (cnt_q == CNT_W'(1));
          cnt_d = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_RUN;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cbdf_fifo.sv
`default_nettype none

module cbdf_fifo import cbdf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire qword_t push_i,
  output logic        full_o,
  output qword_t      head_o,
  input  wire logic   pop_i
);

  entry_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o       = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      priority if (do_push && !do_pop) begin
        count_q <= count_q + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

`default_nettype wire

// File: hdl/cbdf_back.sv
`default_nettype none

module cbdf_back import cbdf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire qword_t             head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [RESP_W-1:0] response_o,
  output logic                    is_last_o
);

  logic                    out_valid_q;
  logic signed [RESP_W-1:0] response_q, response_d;
  logic                    is_last_q;
  logic signed [SUM_W:0]   diff;

  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);
  assign diff  = $signed({1'b0, head_i.entry.right_sum}) -
                 $signed({1'b0, head_i.entry.left_sum});

  always_comb begin
    unique case (head_i.entry.op)
      OP_FILTER: response_d = diff[RESP_W-1:0];
      OP_RAW:    response_d = RESP_W'(head_i.entry.raw);
      default:   response_d = RESP_W'(head_i.entry.raw);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      response_q <= response_d;
      is_last_q  <= head_i.entry.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign response_o  = response_q;
  assign is_last_o   = is_last_q;

endmodule

`default_nettype wire

// File: hdl/caliper_box_difference_filter_core.sv
// Box-difference edge filter along a caliper path. Grey samples arrive one
// word per cycle on the input channel while in_stall_o is low, with
// path_end_i marking the last sample of a path. For half width N (register,
// 1 to 8, reset 2; a write of 0 reads as 1 and anything above 8 as 8), each
// sample with N neighbours on both sides yields the sum of the next N
// samples minus the sum of the previous N; the first and last N samples of
// a path come out raw, and a path shorter than 2N+1 comes out entirely raw.
// Results trail the input by N samples, and the path_end word flushes every
// sample still held, the final result of the path carrying is_last_o.
// Throughput is one input word per cycle while the result queue has room; a
// path_end word then holds the input stalled while its up to N held samples
// are flushed, the front end pushing one result a cycle into the queue when
// it has room. Each result passes through the queue and then the output
// register, which loads it once free. Change the half width only while the
// block is idle.

`default_nettype none

module caliper_box_difference_filter_core import cbdf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration: half width register.
  input  wire logic               cfg_we_i,
  input  wire logic [HW_W-1:0]    cfg_wdata_i,
  // Sample input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [PIX_W-1:0]   pixel_i,
  input  wire logic               path_end_i,
  // Result output channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [RESP_W-1:0] response_o,
  output logic                    is_last_o
);

  logic [HW_W-1:0] half_width_q, half_width_d;
  qword_t          push;
  qword_t          head;
  logic            q_full;
  logic            pop;

  // Out-of-range writes are clamped into the supported half width range.
  always_comb begin
    priority if (cfg_wdata_i < HW_MIN) begin
      half_width_d = HW_MIN;
    end else if (cfg_wdata_i > HW_MAX) begin
      half_width_d = HW_MAX;
    end else begin
      half_width_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HW_RESET;
    end else if (cfg_we_i) begin
      half_width_q <= half_width_d;
    end
  end

  // The front end keeps the sample window, decides which words produce a
  // result and forms both window sums; flushing at a path end runs there too.
  cbdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (half_width_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .path_end_i   (path_end_i),
    .push_o       (push),
    .q_full_i     (q_full)
  );

  // A short queue lets the front keep taking samples while the output stalls.
  cbdf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // The back end forms the difference or passes the raw sample, and holds
  // the result in the output register until it is taken.
  cbdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .response_o  (response_o),
    .is_last_o   (is_last_o)
  );

endmodule

`default_nettype wire

// File: sim/caliper_filter_checker.sv
`default_nettype none

// Watches both channels of the caliper filter, predicts every result from the
// accepted sample words and the half width writes, and compares in order.
module caliper_filter_checker import cbdf_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [HW_W-1:0]          cfg_wdata_i,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_stall_i,
  input  wire logic [PIX_W-1:0]         pixel_i,
  input  wire logic                     path_end_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_stall_i,
  input  wire logic signed [RESP_W-1:0] response_i,
  input  wire logic                     is_last_i,
  output int                            outstanding_o,
  output int                            mismatches_o
);

  typedef struct packed {
    logic signed [RESP_W-1:0] response;
    logic                     is_last;
  } filter_result_t;

  logic [PIX_W-1:0] recent_pixels [WIN_DEPTH];
  logic [HW_W-1:0]  half_width;
  int unsigned      path_pos;
  filter_result_t   due_results [$];
  int               mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Shifts one sample into the window and queues the results it releases.
  task automatic take_sample(input logic [PIX_W-1:0] pix, input logic fin);
    int unsigned              n;
    int unsigned              pos;
    int unsigned              held;
    int                       right_sum;
    int                       left_sum;
    logic signed [RESP_W-1:0] diff;
    n = half_width;
    pos = path_pos;
    for (int i = WIN_DEPTH - 1; i > 0; i--) begin
      recent_pixels[i] = recent_pixels[i-1];
    end
    recent_pixels[0] = pix;
    if (pos >= n) begin
      if (pos >= 2 * n) begin
        right_sum = 0;
        left_sum = 0;
        for (int k = 0; k < n; k++) begin
          right_sum += recent_pixels[k];
          left_sum += recent_pixels[n+1+k];
        end
        diff = RESP_W'(right_sum - left_sum);
      end else begin
        diff = RESP_W'(recent_pixels[n]);
      end
      due_results.insert(due_results.size(), {diff, 1'b0});
    end
    if (fin) begin
      held = (pos >= n) ? n : pos + 1;
      for (int k = held; k > 0; k--) begin
        due_results.insert(due_results.size(),
                           {RESP_W'(recent_pixels[k-1]), (k == 1) ? 1'b1 : 1'b0});
      end
      path_pos = 0;
    end else if (path_pos < WIN_DEPTH) begin
      path_pos++;
    end
  endtask

  task automatic check_result(input logic signed [RESP_W-1:0] resp, input logic last);
    filter_result_t due;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected word, response %0d is_last %0b", resp, last));
    end else begin
      due = due_results.pop_front();
      if (resp !== due.response) begin
        report_mismatch($sformatf("response %0d, predicted %0d", resp, due.response));
      end
      if (last !== due.is_last) begin
        report_mismatch($sformatf("is_last %0b, predicted %0b", last, due.is_last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width = HW_RESET;
      path_pos = 0;
      due_results.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i < HW_MIN) begin
          half_width = HW_MIN;
        end else if (cfg_wdata_i > HW_MAX) begin
          half_width = HW_MAX;
        end else begin
          half_width = cfg_wdata_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(response_i, is_last_i);
      end
      if (in_valid_i && !in_stall_i) begin
        take_sample(pixel_i, path_end_i);
      end
      outstanding_o <= due_results.size();
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_caliper_box_difference_filter_core.sv
`default_nettype none

// Top of the caliper filter bench. It only produces stimulus and states the
// verdict; all prediction and comparison happens in the checker next to the
// block.
module tb_caliper_box_difference_filter_core;
  import cbdf_pkg::*;

  localparam int MAX_IDLE       = 12;
  localparam int PHASE_WORDS    = 24;
  localparam int SQUEEZE_CYCLES = 60;
  localparam int SQUEEZE_PATH   = 30;
  localparam int LONGEST_PATH   = 40;
  localparam int NUM_PHASES     = 12;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [HW_W-1:0]          cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [PIX_W-1:0]         pixel = '0;
  logic                     path_end = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [RESP_W-1:0] response;
  logic                     is_last;

  int outstanding;
  int mismatches;

  // Handshake between the stimulus and the receiver: the stimulus asks for one
  // long hold-off and meanwhile offers words back to back.
  bit squeeze_req = 1'b0;
  bit no_gaps = 1'b0;

  // Sender idling comes in stretches, some with gaps and some without.
  int send_stretch = 0;
  bit send_idles = 1'b0;

  // The directed paths run at the reset half width of 2. They cover a lone
  // sample that is also the path end, a path too short for any filtered
  // result, rising and falling steps with both extreme pixel values, and a
  // path of exactly 2N+1 samples.
  logic [PIX_W-1:0] directed_pixels [19] = '{
    8'd255,
    8'd0, 8'd255, 8'd128, 8'd1,
    8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
    8'd255, 8'd255, 8'd0, 8'd0, 8'd0
  };
  bit directed_ends [19] = '{
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1
  };

  // Half width settings per random phase; 0 and 15 lie outside the legal range
  // and are clamped by the block. The long hold-off runs in the phase at 8,
  // where the flush after a path end is longest.
  logic [HW_W-1:0] phase_widths [NUM_PHASES] = '{
    4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd7, 4'd4, 4'd6, 4'd1
  };

  caliper_box_difference_filter_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_i     (pixel),
    .path_end_i  (path_end),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .response_o  (response),
    .is_last_o   (is_last)
  );

  caliper_filter_checker filter_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .pixel_i       (pixel),
    .path_end_i    (path_end),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .response_i    (response),
    .is_last_i     (is_last),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one sample word after a random gap and returns at the clock edge
  // that accepts it. Valid stays high into the next word when there is no gap,
  // so it is never lowered and raised in the same time step.
  task automatic send_word(input logic [PIX_W-1:0] pix, input logic fin);
    int gap;
    if (send_stretch == 0) begin
      send_stretch = $urandom_range(8, 40);
      send_idles = ($urandom_range(0, 2) != 0);
    end
    send_stretch--;
    gap = (send_idles && !no_gaps) ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    path_end <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends one path of the given length. With a negative step position the
  // pixels are random, with a bias toward the extremes; otherwise the path is
  // a clean step between 0 and 255, which drives the response to its limits.
  task automatic send_path(input int len, input int step, input bit falling);
    logic [PIX_W-1:0] pix;
    for (int i = 0; i < len; i++) begin
      if (step >= 0) begin
        pix = ((i < step) ^ falling) ? '0 : '1;
      end else if ($urandom_range(0, 3) == 0) begin
        pix = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        pix = PIX_W'($urandom_range(0, 255));
      end
      send_word(pix, i == len - 1);
    end
  endtask

  // Drops valid, waits for every predicted word to arrive, and then lets the
  // two-stage output path settle before a register write.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_half_width(input logic [HW_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase at a fixed half width. Every phase ends on a path end, so
  // the block holds no samples when the register changes.
  task automatic random_phase(input logic [HW_W-1:0] setting, input bit squeeze);
    int n;
    int len;
    int done;
    n = (setting < HW_MIN) ? HW_MIN : (setting > HW_MAX) ? HW_MAX : setting;
    write_half_width(setting);
    done = 0;
    if (squeeze) begin
      no_gaps = 1'b1;
      squeeze_req = 1'b1;
      send_path(SQUEEZE_PATH, -1, 1'b0);
      no_gaps = 1'b0;
      done = SQUEEZE_PATH;
    end
    while (done < PHASE_WORDS) begin
      case ($urandom_range(0, 4))
        0: begin
          len = $urandom_range(1, 2 * n);
          send_path(len, -1, 1'b0);
        end
        1: begin
          len = $urandom_range(2 * n + 1, 2 * n + 3);
          send_path(len, -1, 1'b0);
        end
        2: begin
          len = $urandom_range(1, LONGEST_PATH);
          send_path(len, -1, 1'b0);
        end
        3: begin
          len = $urandom_range(2 * n + 1, 3 * n + 6);
          send_path(len, -1, 1'b0);
        end
        default: begin
          len = $urandom_range(2 * n + 1, LONGEST_PATH);
          send_path(len, $urandom_range(0, len), 1'($urandom_range(0, 1)));
        end
      endcase
      done += len;
    end
    drain_block();
  endtask

  // Receiver: holds off for a random number of cycles before each word, in
  // stretches with and without idling. On request it holds off once for a long
  // time so that the result queue fills and the block stalls its input.
  initial begin
    int hold;
    int recv_stretch;
    bit recv_idles;
    recv_stretch = 0;
    recv_idles = 1'b0;
    forever begin
      if (squeeze_req) begin
        hold = SQUEEZE_CYCLES;
        squeeze_req = 1'b0;
      end else begin
        if (recv_stretch == 0) begin
          recv_stretch = $urandom_range(8, 40);
          recv_idles = ($urandom_range(0, 2) != 0);
        end
        recv_stretch--;
        hold = recv_idles ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 19; i++) begin
      send_word(directed_pixels[i], directed_ends[i]);
    end
    drain_block();
    for (int p = 0; p < NUM_PHASES; p++) begin
      random_phase(phase_widths[p], p == 1);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
